// ===== design/assert_macros.svh =====
// Assertion macro used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion with asynchronous reset disable
`define TGQ_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`endif

// ===== design/tgq_pkg.sv =====
// Types, sizes and codes of the team grouped queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tgq_pkg;
    localparam int QUEUE_DEPTH = 256;
    localparam int TEAM_COUNT  = 1024;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int VALUE_W     = 20;
    localparam int TEAM_W      = 10;
    localparam int TAG_W       = TEAM_W + 1;
    localparam int NODE_W      = VALUE_W + TAG_W + PTR_W;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
        ptr_t               next;
    } node_t;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MATCH,
        S_TAILRD,
        S_LINK,
        S_NEW,
        S_DQ
    } state_t;

    typedef struct packed {
        logic  we;
        ptr_t  waddr;
        node_t wdata;
        ptr_t  raddr;
    } node_port_t;

    typedef struct packed {
        logic              we;
        logic [TEAM_W-1:0] waddr;
        ptr_t              wdata;
        logic [TEAM_W-1:0] raddr;
    } team_port_t;

    typedef struct packed {
        logic we;
        ptr_t waddr;
        ptr_t wdata;
        ptr_t raddr;
    } free_port_t;
endpackage
`default_nettype wire

// ===== design/team_grouped_queue.sv =====
// Top level of the team grouped queue: sequencer plus node, team and free RAMs.
// Depends on tgq_pkg, tgq_ram and tgq_ctrl.
//
// Usage: drive action, element, team_id and has_team with start high; the
// request is taken at a clock edge where start is high and busy is low.
// action 0 enqueues: an element with has_team high and an in-range team goes
// directly behind the last queued member of its team, otherwise at the
// tail. action 1 dequeues the front element.
// Each request gives one result: done is high for exactly one cycle with
// status and front_value; the receiver cannot stall it.
// Empty dequeue and full enqueue answer in the cycle after the request;
// a dequeue passes through S_DQ; an enqueue through S_LOOK, then S_MATCH
// and S_TAILRD as needed for the dependent team tail and node RAM reads,
// then S_LINK if needed and S_NEW to splice it in. busy stays high meanwhile.
// A new request may be given in the cycle that done is high.
// Reset empties the queue at once; the RAMs need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module team_grouped_queue
    import tgq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               action,
    input  wire logic [VALUE_W-1:0] element,
    input  wire logic [TEAM_W-1:0]  team_id,
    input  wire logic               has_team,
    output logic                    busy,
    output logic                    done,
    output logic [1:0]              status,
    output logic [VALUE_W-1:0]      front_value
);
    node_port_t node_port;
    team_port_t team_port;
    free_port_t free_port;
    logic [NODE_W-1:0] node_raw;
    ptr_t team_rdata, free_rdata;

    tgq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .element(element), .team_id(team_id), .has_team(has_team),
        .busy(busy), .done(done), .status(status), .front_value(front_value),
        .node_port(node_port), .node_rdata(node_t'(node_raw)),
        .team_port(team_port), .team_rdata(team_rdata),
        .free_port(free_port), .free_rdata(free_rdata)
    );

    tgq_ram #(.WIDTH(NODE_W), .DEPTH(QUEUE_DEPTH)) u_node_ram (
        .clk(clk), .we(node_port.we), .waddr(node_port.waddr),
        .wdata(NODE_W'(node_port.wdata)), .raddr(node_port.raddr), .rdata(node_raw)
    );

    tgq_ram #(.WIDTH(PTR_W), .DEPTH(2 ** TEAM_W)) u_team_ram (
        .clk(clk), .we(team_port.we), .waddr(team_port.waddr),
        .wdata(team_port.wdata), .raddr(team_port.raddr), .rdata(team_rdata)
    );

    tgq_ram #(.WIDTH(PTR_W), .DEPTH(QUEUE_DEPTH)) u_free_ram (
        .clk(clk), .we(free_port.we), .waddr(free_port.waddr),
        .wdata(free_port.wdata), .raddr(free_port.raddr), .rdata(free_rdata)
    );
endmodule
`default_nettype wire

// ===== design/tgq_ram.sv =====
// Generic simple dual port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/tgq_ctrl.sv =====
// Sequencer of the team grouped queue: linked node list, team tails, free stack.
// Depends on tgq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tgq_ctrl
    import tgq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               action,
    input  wire logic [VALUE_W-1:0] element,
    input  wire logic [TEAM_W-1:0]  team_id,
    input  wire logic               has_team,
    output logic                    busy,
    output logic                    done,
    output logic [1:0]              status,
    output logic [VALUE_W-1:0]      front_value,
    output node_port_t              node_port,
    input  wire node_t              node_rdata,
    output team_port_t              team_port,
    input  wire ptr_t               team_rdata,
    output free_port_t              free_port,
    input  wire ptr_t               free_rdata
);
    state_t state_reg, state_next;
    cnt_t count_reg, count_next, sp_reg, sp_next, fresh_reg, fresh_next;
    ptr_t head_reg, head_next, tail_reg, tail_next;
    ptr_t n_reg, n_next, l_reg, l_next, p_reg, p_next;
    logic have_l_reg, have_l_next;
    node_t w_reg, w_next;
    logic [VALUE_W-1:0] elem_reg, elem_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [TEAM_W-1:0] team_reg, team_next;
    logic done_reg, done_next;
    status_t status_reg, status_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic in_range;
    logic p_known;

    assign in_range = {1'b0, team_id} < TAG_W'(TEAM_COUNT);

    // trust a team tail only if it points at a node written since reset, other than the new node
    assign p_known = ({1'b0, p_reg} < fresh_reg) && (p_reg != n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            sp_reg     <= '0;
            fresh_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_ENQ;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sp_reg     <= sp_next;
            fresh_reg  <= fresh_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        l_reg      <= l_next;
        p_reg      <= p_next;
        have_l_reg <= have_l_next;
        w_reg      <= w_next;
        elem_reg   <= elem_next;
        tag_reg    <= tag_next;
        team_reg   <= team_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sp_next     = sp_reg;
        fresh_next  = fresh_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        n_next      = n_reg;
        l_next      = l_reg;
        p_next      = p_reg;
        have_l_next = have_l_reg;
        w_next      = w_reg;
        elem_next   = elem_reg;
        tag_next    = tag_reg;
        team_next   = team_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        node_port   = '{we: 1'b0, waddr: '0, wdata: '0, raddr: head_reg};
        team_port   = '{we: 1'b0, waddr: team_reg, wdata: n_reg, raddr: team_id};
        free_port   = '{we: 1'b0, waddr: sp_reg[PTR_W-1:0], wdata: head_reg,
                        raddr: PTR_W'(sp_reg - 1'b1)};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    elem_next = element;
                    team_next = team_id;
                    tag_next  = (has_team && in_range) ? {1'b1, team_id} : '0;
                    if (action)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                            value_next  = '0;
                        end
                        else
                        begin
                            state_next = S_DQ;
                        end
                    end
                    else if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        value_next  = '0;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (sp_reg != '0)
                begin
                    n_next  = free_rdata;
                    sp_next = sp_reg - 1'b1;
                end
                else
                begin
                    n_next     = fresh_reg[PTR_W-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end
                have_l_next = 1'b0;
                if (tag_reg != '0)
                begin
                    p_next          = team_rdata;
                    node_port.raddr = team_rdata;
                    state_next      = S_MATCH;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    node_port.raddr = tail_reg;
                    state_next      = S_TAILRD;
                end
            end
            S_MATCH:
            begin
                if (p_known && (node_rdata.tag == tag_reg))
                begin
                    w_next      = node_rdata;
                    l_next      = p_reg;
                    have_l_next = 1'b1;
                    state_next  = S_LINK;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_NEW;
                end
                else
                begin
                    node_port.raddr = tail_reg;
                    state_next      = S_TAILRD;
                end
            end
            S_TAILRD:
            begin
                w_next      = node_rdata;
                l_next      = tail_reg;
                have_l_next = 1'b1;
                state_next  = S_LINK;
            end
            S_LINK:
            begin
                node_port.we    = 1'b1;
                node_port.waddr = l_reg;
                node_port.wdata = '{value: w_reg.value, tag: w_reg.tag, next: n_reg};
                state_next      = S_NEW;
            end
            S_NEW:
            begin
                node_port.we    = 1'b1;
                node_port.waddr = n_reg;
                node_port.wdata = '{value: elem_reg, tag: tag_reg,
                                    next: have_l_reg ? w_reg.next : '0};
                team_port.we    = (tag_reg != '0);
                if (!have_l_reg)
                begin
                    head_next = n_reg;
                end
                if (!have_l_reg || (l_reg == tail_reg))
                begin
                    tail_next = n_reg;
                end
                count_next  = count_reg + 1'b1;
                done_next   = 1'b1;
                status_next = ST_ENQ;
                value_next  = '0;
                state_next  = S_IDLE;
            end
            S_DQ:
            begin
                node_port.we    = 1'b1;
                node_port.waddr = head_reg;
                node_port.wdata = '0;
                free_port.we    = 1'b1;
                sp_next         = sp_reg + 1'b1;
                head_next       = node_rdata.next;
                count_next      = count_reg - 1'b1;
                done_next       = 1'b1;
                status_next     = ST_DEQ;
                value_next      = node_rdata.value;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign front_value = value_reg;
endmodule
`default_nettype wire

// ===== design/tgq_checker.sv =====
// Port level checks of the team grouped queue, bound to the top level.
// Depends on tgq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tgq_checker
    import tgq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic [1:0]         status,
    input wire logic [VALUE_W-1:0] front_value
);
    `TGQ_ASSERT(a_done_idle, clk, rst_n, done |-> !busy, "result while busy")
    `TGQ_ASSERT(a_req_result, clk, rst_n, (start && !busy) |=> (busy || done), "request lost")
    `TGQ_ASSERT(a_done_cause, clk, rst_n, done |-> ($past(start) || $past(busy)), "result without request")
    `TGQ_ASSERT(a_value_zero, clk, rst_n, (done && (status != ST_DEQ)) |-> (front_value == '0), "value not zero")
endmodule

bind team_grouped_queue tgq_checker u_tgq_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .front_value(front_value)
);
`default_nettype wire
